// ===== hw/rtl/sbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbcs_pkg
// shared types and constants of the shared bus collision station
// ----------------------------------------------------------------------------
package sbcs_pkg;

    localparam int TX_DEPTH_DEF = 32;
    localparam int RX_DEPTH_DEF = 32;

    localparam logic [7:0] SYM_IDLE  = 8'h00;
    localparam logic [7:0] SYM_CLAIM = 8'hFF;
    localparam logic [7:0] SYM_JAM   = 8'hFE;

    localparam logic [3:0] ATTEMPT_LIMIT_RST = 4'd10;
    localparam logic [3:0] BACKOFF_STEP_RST  = 4'd8;
    localparam logic [1:0] IDLE_HOLD_RST     = 2'd2;

    localparam logic [1:0] CFG_ATTEMPT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BACKOFF_STEP  = 2'd1;
    localparam logic [1:0] CFG_IDLE_HOLD     = 2'd2;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_CLAIM    = 3'd1;
    localparam logic [2:0] ST_JAM      = 3'd2;
    localparam logic [2:0] ST_GAVE_UP  = 3'd3;
    localparam logic [2:0] ST_SENT     = 3'd4;
    localparam logic [2:0] ST_BACKOFF  = 3'd5;
    localparam logic [2:0] ST_UNSENT   = 3'd6;
    localparam logic [2:0] ST_REJECTED = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_MOD,
        S_OUT
    } t_state;

    // request to the modulo unit
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [7:0]  divisor;
    } t_mod_req;

    // reply from the modulo unit
    typedef struct packed {
        logic       done;
        logic [7:0] remainder;
    } t_mod_rsp;

endpackage

// ===== hw/rtl/sbcs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// sbcs_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module sbcs_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbcs_pkg::t_mod_req i_req,
    output sbcs_pkg::t_mod_rsp o_rsp
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [15:0] r_dvd;
    logic [7:0]  r_dvs;
    logic [8:0]  r_rem;
    logic        r_done;
    logic [8:0]  w_sh;

    // shift in next dividend bit and conditionally subtract
    assign w_sh = {r_rem[7:0], r_dvd[15]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[14:0], 1'b0};
                if (w_sh >= {1'b0, r_dvs}) r_rem <= w_sh - {1'b0, r_dvs};
                else                       r_rem <= w_sh;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[7:0];

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_done) begin
            assert (r_rem < {1'b0, r_dvs})
                else $error("remainder not below divisor");
        end
    end

    property p_start_busy;
        @(posedge i_clk) disable iff (!i_rst_n) i_req.start |=> r_busy;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("unit not busy after start");

    property p_done_once;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done;
    endproperty
    a_done_once: assert property (p_done_once) else $error("done held two cycles");

endmodule

// ===== hw/rtl/shared_bus_collision_station_core.sv =====
// ----------------------------------------------------------------------------
// shared_bus_collision_station_core
// carrier-sense station with collision detection and random backoff
// ----------------------------------------------------------------------------
// sequencing: a load passes through the read and output states; a channel tick passes
// through the same states, adding a drain state when received bytes are emptied on idle
// and a modulo state for a backoff draw on the bit-serial modulo unit
// throughput: one transaction at a time; the next is accepted only once the station is idle
// and its last result has been taken, so each result that waits for ready adds its wait
// reset: synchronous active low, clears control state and loads register defaults
module shared_bus_collision_station_core #(
    parameter int TX_DEPTH = sbcs_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = sbcs_pkg::RX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_channel_value,
    input  logic [15:0] i_random_value,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_tx_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic        o_drive_enable,
    output logic [7:0]  o_drive_value,
    output logic [7:0]  o_rx_byte,
    output logic        o_rx_last,
    output logic [2:0]  o_status
);

    localparam int TXW = $clog2(TX_DEPTH);
    localparam int RXW = $clog2(RX_DEPTH);
    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam int RCW = $clog2(RX_DEPTH + 1);

    // configuration registers
    logic [3:0] r_attempt_limit, r_backoff_step;
    logic [1:0] r_idle_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attempt_limit <= sbcs_pkg::ATTEMPT_LIMIT_RST;
            r_backoff_step  <= sbcs_pkg::BACKOFF_STEP_RST;
            r_idle_hold     <= sbcs_pkg::IDLE_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbcs_pkg::CFG_ATTEMPT_LIMIT: r_attempt_limit <= i_cfg_data;
                sbcs_pkg::CFG_BACKOFF_STEP:  r_backoff_step  <= i_cfg_data;
                sbcs_pkg::CFG_IDLE_HOLD:     r_idle_hold     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // stores
    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] r_tx_rd, r_tx_nx, r_rx_rd;

    // state
    sbcs_pkg::t_state r_state, n_state;
    logic [TCW-1:0] r_tx_len, n_tx_len, r_tx_pos, n_tx_pos;
    logic [RCW-1:0] r_rx_cnt, n_rx_cnt, r_drain, n_drain;
    logic           r_tx_rdy, n_tx_rdy, r_jam_own, n_jam_own;
    logic [3:0]     r_coll, n_coll;
    logic [7:0]     r_boff, n_boff;
    logic [1:0]     r_idle, n_idle;

    // latched transaction
    logic        r_act, r_last;
    logic [7:0]  r_ch, r_tb;
    logic [15:0] r_rnd;

    // output register
    logic       r_ov, n_ov;
    logic       r_kind, n_kind, r_en, n_en, r_olast, n_olast;
    logic [7:0] r_dv, n_dv, r_rb, n_rb;
    logic [2:0] r_st, n_st;

    // memory control
    logic           w_tx_we, w_rx_we;
    logic [TXW-1:0] w_tx_wa, w_tx_ra, w_tx_na;
    logic [RXW-1:0] w_rx_wa, w_rx_ra;
    logic [7:0]     w_tx_wd, w_rx_wd;

    sbcs_pkg::t_mod_req w_req;
    sbcs_pkg::t_mod_rsp w_rsp;
    logic [7:0]         w_win;

    sbcs_mod_unit u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_tx_we) tx_mem[w_tx_wa] <= w_tx_wd;
        r_tx_rd <= tx_mem[w_tx_ra];
        r_tx_nx <= tx_mem[w_tx_na];
        if (w_rx_we) rx_mem[w_rx_wa] <= w_rx_wd;
        r_rx_rd <= rx_mem[w_rx_ra];
    end

    assign o_ready = (r_state == sbcs_pkg::S_IDLE) && !r_ov;
    assign w_win   = 8'd1 + 8'(r_coll) * 8'(r_backoff_step);

    // control register update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sbcs_pkg::S_IDLE;
            r_tx_len  <= '0;
            r_tx_pos  <= '0;
            r_rx_cnt  <= '0;
            r_drain   <= '0;
            r_tx_rdy  <= 1'b0;
            r_jam_own <= 1'b0;
            r_coll    <= '0;
            r_boff    <= '0;
            r_idle    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tx_len  <= n_tx_len;
            r_tx_pos  <= n_tx_pos;
            r_rx_cnt  <= n_rx_cnt;
            r_drain   <= n_drain;
            r_tx_rdy  <= n_tx_rdy;
            r_jam_own <= n_jam_own;
            r_coll    <= n_coll;
            r_boff    <= n_boff;
            r_idle    <= n_idle;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_en    <= n_en;
        r_dv    <= n_dv;
        r_rb    <= n_rb;
        r_olast <= n_olast;
        r_st    <= n_st;
        if (i_valid && o_ready) begin
            r_act  <= i_action;
            r_ch   <= i_channel_value;
            r_rnd  <= i_random_value;
            r_tb   <= i_tx_byte;
            r_last <= i_tx_last;
        end
    end

    // sequencer
    always_comb begin
        logic may_send, in_msg;
        logic [TCW-1:0] pos1;
        n_state   = r_state;
        n_tx_len  = r_tx_len;
        n_tx_pos  = r_tx_pos;
        n_rx_cnt  = r_rx_cnt;
        n_drain   = r_drain;
        n_tx_rdy  = r_tx_rdy;
        n_jam_own = r_jam_own;
        n_coll    = r_coll;
        n_boff    = r_boff;
        n_idle    = r_idle;
        n_ov      = r_ov && !i_ready;
        n_kind    = r_kind;
        n_en      = r_en;
        n_dv      = r_dv;
        n_rb      = r_rb;
        n_olast   = r_olast;
        n_st      = r_st;
        w_tx_we   = 1'b0;
        w_tx_wa   = r_tx_len[TXW-1:0];
        w_tx_wd   = r_tb;
        w_tx_ra   = r_tx_pos[TXW-1:0];
        w_rx_we   = 1'b0;
        w_rx_wa   = r_rx_cnt[RXW-1:0];
        w_rx_wd   = r_ch;
        w_rx_ra   = r_drain[RXW-1:0];
        w_req.start    = 1'b0;
        w_req.dividend = r_rnd;
        w_req.divisor  = w_win;
        may_send  = r_tx_rdy && (r_boff == 8'd0) && !r_jam_own;
        in_msg    = r_tx_pos < r_tx_len;
        pos1      = r_tx_pos + TCW'(1);
        w_tx_na   = pos1[TXW-1:0];
        case (r_state)
            sbcs_pkg::S_IDLE: begin
                if (i_valid && o_ready) n_state = sbcs_pkg::S_READ;
            end
            // memory read of the current message byte, or load write; a tick picks drain, modulo or outcome
            sbcs_pkg::S_READ: begin
                n_kind  = 1'b0;
                n_en    = 1'b0;
                n_dv    = sbcs_pkg::SYM_IDLE;
                n_rb    = 8'd0;
                n_olast = 1'b1;
                n_st    = sbcs_pkg::ST_NONE;
                if (r_act) begin
                    if (r_tx_rdy || r_tb == sbcs_pkg::SYM_IDLE || r_tb == sbcs_pkg::SYM_JAM ||
                        r_tb == sbcs_pkg::SYM_CLAIM || r_tx_len >= TCW'(TX_DEPTH)) begin
                        n_st = sbcs_pkg::ST_REJECTED;
                    end else begin
                        w_tx_we  = 1'b1;
                        n_tx_len = r_tx_len + TCW'(1);
                        if (r_last) begin
                            n_tx_rdy = 1'b1;
                            n_tx_pos = '0;
                        end
                    end
                    n_ov    = 1'b1;
                    n_state = sbcs_pkg::S_OUT;
                end else begin
                    n_drain = '0;
                    n_state = (r_ch == sbcs_pkg::SYM_IDLE && r_rx_cnt != '0)
                              ? sbcs_pkg::S_DRAIN : sbcs_pkg::S_OUT;
                    if (r_ch == sbcs_pkg::SYM_JAM && r_jam_own) begin
                        w_req.start = 1'b1;
                        n_state     = sbcs_pkg::S_MOD;
                    end
                end
            end
            // one received byte per cycle while the output register is free; read data is registered
            sbcs_pkg::S_DRAIN: begin
                if (!r_ov) begin
                    if (r_drain != '0) begin
                        n_kind  = 1'b1;
                        n_en    = 1'b0;
                        n_dv    = 8'd0;
                        n_rb    = r_rx_rd;
                        n_olast = 1'b0;
                        n_st    = sbcs_pkg::ST_NONE;
                        n_ov    = 1'b1;
                    end
                    if (r_drain == r_rx_cnt) begin
                        n_rx_cnt = '0;
                        n_state  = sbcs_pkg::S_OUT;
                    end else begin
                        n_drain = r_drain + RCW'(1);
                    end
                end else begin
                    w_rx_ra = RXW'(r_drain - RCW'(1));
                end
            end
            sbcs_pkg::S_MOD: begin
                if (w_rsp.done) n_state = sbcs_pkg::S_OUT;
            end
            // tick outcome; a load only waits here for its result to be taken
            sbcs_pkg::S_OUT: begin
                if (r_act) begin
                    if (!n_ov) n_state = sbcs_pkg::S_IDLE;
                end else if (!r_ov) begin
                    n_kind  = 1'b0;
                    n_en    = 1'b0;
                    n_dv    = 8'd0;
                    n_rb    = 8'd0;
                    n_olast = 1'b1;
                    n_st    = sbcs_pkg::ST_NONE;
                    if (r_ch == sbcs_pkg::SYM_IDLE) begin
                        n_jam_own = 1'b0;
                        if (r_idle < r_idle_hold) begin
                            n_idle = r_idle + 2'd1;
                        end else begin
                            n_idle   = '0;
                            n_tx_pos = '0;
                            if (r_tx_rdy) begin
                                if (r_boff == 8'd0) begin
                                    n_en = 1'b1;
                                    n_dv = sbcs_pkg::SYM_CLAIM;
                                    n_st = sbcs_pkg::ST_CLAIM;
                                end else begin
                                    n_st = sbcs_pkg::ST_UNSENT;
                                end
                            end
                        end
                    end else if (r_ch == sbcs_pkg::SYM_CLAIM) begin
                        if (may_send && in_msg) begin
                            n_en = 1'b1;
                            n_dv = r_tx_rd;
                        end
                    end else if (r_ch == sbcs_pkg::SYM_JAM) begin
                        n_rx_cnt = '0;
                        n_tx_pos = '0;
                        if (r_jam_own) begin
                            n_jam_own = 1'b0;
                            n_en      = 1'b1;
                            n_st      = sbcs_pkg::ST_BACKOFF;
                            n_boff    = w_rsp.remainder;
                        end
                    end else if (may_send && in_msg) begin
                        if (r_ch == r_tx_rd) begin
                            if (r_rx_cnt < RCW'(RX_DEPTH)) begin
                                w_rx_we  = 1'b1;
                                n_rx_cnt = r_rx_cnt + RCW'(1);
                            end
                            n_en = 1'b1;
                            if (pos1 >= r_tx_len) begin
                                n_tx_rdy = 1'b0;
                                n_tx_len = '0;
                                n_tx_pos = '0;
                                n_coll   = '0;
                                n_st     = sbcs_pkg::ST_SENT;
                            end else begin
                                // next byte comes from the second read port
                                n_tx_pos = pos1;
                                n_dv     = r_tx_nx;
                            end
                        end else begin
                            n_en      = 1'b1;
                            n_dv      = sbcs_pkg::SYM_JAM;
                            n_st      = sbcs_pkg::ST_JAM;
                            n_jam_own = 1'b1;
                            n_tx_pos  = '0;
                            if (r_coll != 4'd15) n_coll = r_coll + 4'd1;
                            if (((r_coll != 4'd15) ? r_coll + 4'd1 : r_coll)
                                >= r_attempt_limit) begin
                                n_tx_rdy = 1'b0;
                                n_tx_len = '0;
                                n_coll   = '0;
                                n_st     = sbcs_pkg::ST_GAVE_UP;
                            end
                        end
                    end else if (r_rx_cnt < RCW'(RX_DEPTH)) begin
                        w_rx_we  = 1'b1;
                        n_rx_cnt = r_rx_cnt + RCW'(1);
                    end
                    // backoff counts down at the end of each tick; an own jam loads the drawn value less one
                    if (n_boff != 8'd0 && !(r_ch == sbcs_pkg::SYM_JAM && r_jam_own))
                        n_boff = r_boff - 8'd1;
                    else if (r_ch == sbcs_pkg::SYM_JAM && r_jam_own && w_rsp.remainder != 8'd0)
                        n_boff = w_rsp.remainder - 8'd1;
                    n_ov = 1'b1;
                    if (n_state == sbcs_pkg::S_OUT) n_state = sbcs_pkg::S_IDLE;
                end
            end
            default: n_state = sbcs_pkg::S_IDLE;
        endcase
    end

    assign o_valid        = r_ov;
    assign o_result_kind  = r_kind;
    assign o_drive_enable = r_en;
    assign o_drive_value  = r_dv;
    assign o_rx_byte      = r_rb;
    assign o_rx_last      = r_olast;
    assign o_status       = r_st;

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != sbcs_pkg::S_IDLE) |-> !o_ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

    property p_pos_in_len;
        @(posedge i_clk) disable iff (!i_rst_n) r_tx_pos <= r_tx_len;
    endproperty
    a_pos_in_len: assert property (p_pos_in_len) else $error("position beyond length");

    property p_rx_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_rx_cnt <= RCW'(RX_DEPTH);
    endproperty
    a_rx_bound: assert property (p_rx_bound) else $error("receive count overflow");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the collision station core against a cycle-free behavioral predictor:
// a directed table of loads and channel ticks, then message-shaped random
// traffic over several register settings and handshake idling patterns
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = sbcs_pkg::TX_DEPTH_DEF;
    localparam int CYC_LIMIT = 600000;
    localparam int N_RANDOM  = 280;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_action = 1'b0;
    logic [7:0]  i_channel_value = '0;
    logic [15:0] i_random_value = '0;
    logic [7:0]  i_tx_byte = '0;
    logic        i_tx_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_result_kind;
    logic        o_drive_enable;
    logic [7:0]  o_drive_value;
    logic [7:0]  o_rx_byte;
    logic        o_rx_last;
    logic [2:0]  o_status;

    shared_bus_collision_station_core dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic       kind;
        logic       en;
        logic [7:0] dv;
        logic [7:0] rb;
        logic       last;
        logic [2:0] st;
    } t_station_out;

    typedef struct {
        logic        act;
        logic [7:0]  ch;
        logic [15:0] rnd;
        logic [7:0]  tb;
        logic        tl;
        bit          typed;
        logic        t_en;
        logic [7:0]  t_dv;
        logic [2:0]  t_st;
    } t_dir_row;

    t_station_out station_outs[$];
    int           fail_cnt = 0;
    int           cyc = 0;
    int           idle_mode = 0;

    // station copy: registers and state
    logic [3:0] m_limit, m_step;
    logic [1:0] m_hold;
    logic [7:0] m_tx[DEPTH];
    logic [7:0] m_rx[DEPTH];
    int         m_txlen, m_txpos, m_rxcnt;
    bit         m_ready, m_jam_own;
    logic [3:0] m_coll;
    logic [7:0] m_boff;
    logic [1:0] m_seen;
    // what the station drove last, used to shape echoes
    logic       last_en;
    logic [7:0] last_dv;

    // cycle limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("shared_bus_collision_station_core verification failed");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        case (idle_mode)
            2: i_ready <= ($urandom_range(0, 99) >= 82);
            3: i_ready <= ($urandom_range(0, 99) >= 16);
            default: i_ready <= 1'b1;
        endcase
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_station_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (station_outs.size() == 0) begin
                $error("result with nothing expected");
                fail_cnt++;
            end else begin
                e = station_outs.pop_front();
                if (o_result_kind !== e.kind) begin
                    $error("result_kind exp %0d got %0d", e.kind, o_result_kind);
                    fail_cnt++;
                end
                if (o_drive_enable !== e.en) begin
                    $error("drive_enable exp %0d got %0d", e.en, o_drive_enable);
                    fail_cnt++;
                end
                if (o_drive_value !== e.dv) begin
                    $error("drive_value exp %0h got %0h", e.dv, o_drive_value);
                    fail_cnt++;
                end
                if (o_rx_byte !== e.rb) begin
                    $error("rx_byte exp %0h got %0h", e.rb, o_rx_byte);
                    fail_cnt++;
                end
                if (o_rx_last !== e.last) begin
                    $error("rx_last exp %0d got %0d", e.last, o_rx_last);
                    fail_cnt++;
                end
                if (o_status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_status);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic station_reset();
        m_limit = sbcs_pkg::ATTEMPT_LIMIT_RST;
        m_step  = sbcs_pkg::BACKOFF_STEP_RST;
        m_hold  = sbcs_pkg::IDLE_HOLD_RST;
        m_txlen = 0; m_txpos = 0; m_rxcnt = 0;
        m_ready = 0; m_jam_own = 0;
        m_coll = '0; m_boff = '0; m_seen = '0;
        last_en = 1'b0; last_dv = '0;
    endtask

    task automatic drop_msg();
        m_ready = 0; m_txlen = 0; m_txpos = 0; m_coll = '0;
    endtask

    // predicts one transaction; received bytes go straight to the queue,
    // the closing outcome is handed back
    task automatic station_predict(input logic act, input logic [7:0] c,
                                   input logic [15:0] rnd, input logic [7:0] tb,
                                   input logic tl, output t_station_out fin);
        bit           may_send;
        int           win;
        t_station_out r;
        fin = '{kind: 1'b0, en: 1'b0, dv: 8'h00, rb: 8'h00, last: 1'b1,
                st: sbcs_pkg::ST_NONE};
        if (act) begin
            if (m_ready || tb == sbcs_pkg::SYM_IDLE || tb == sbcs_pkg::SYM_JAM ||
                tb == sbcs_pkg::SYM_CLAIM || m_txlen >= DEPTH) begin
                fin.st = sbcs_pkg::ST_REJECTED;
            end else begin
                m_tx[m_txlen] = tb;
                m_txlen++;
                if (tl) begin
                    m_ready = 1; m_txpos = 0;
                end
            end
        end else begin
            may_send = m_ready && m_boff == 0 && !m_jam_own;
            if (c == sbcs_pkg::SYM_IDLE) begin
                for (int i = 0; i < m_rxcnt; i++) begin
                    r = '{kind: 1'b1, en: 1'b0, dv: 8'h00, rb: m_rx[i], last: 1'b0,
                          st: sbcs_pkg::ST_NONE};
                    station_outs.push_back(r);
                end
                m_rxcnt = 0;
                m_jam_own = 0;
                if (m_seen < m_hold) begin
                    m_seen++;
                end else begin
                    m_seen = 0;
                    m_txpos = 0;
                    if (m_ready) begin
                        if (m_boff == 0) begin
                            fin.en = 1; fin.dv = sbcs_pkg::SYM_CLAIM;
                            fin.st = sbcs_pkg::ST_CLAIM;
                        end else begin
                            fin.st = sbcs_pkg::ST_UNSENT;
                        end
                    end
                end
            end else if (c == sbcs_pkg::SYM_CLAIM) begin
                if (may_send && m_txpos < m_txlen) begin
                    fin.en = 1; fin.dv = m_tx[m_txpos];
                end
            end else if (c == sbcs_pkg::SYM_JAM) begin
                m_rxcnt = 0;
                m_txpos = 0;
                if (m_jam_own) begin
                    win = 1 + int'(m_coll) * int'(m_step);
                    m_jam_own = 0;
                    fin.en = 1; fin.dv = sbcs_pkg::SYM_IDLE; fin.st = sbcs_pkg::ST_BACKOFF;
                    m_boff = 8'(int'(rnd) % win);
                end
            end else begin
                if (may_send && m_txpos < m_txlen) begin
                    if (c == m_tx[m_txpos]) begin
                        if (m_rxcnt < DEPTH) begin
                            m_rx[m_rxcnt] = c; m_rxcnt++;
                        end
                        m_txpos++;
                        fin.en = 1;
                        if (m_txpos >= m_txlen) begin
                            drop_msg();
                            fin.dv = sbcs_pkg::SYM_IDLE; fin.st = sbcs_pkg::ST_SENT;
                        end else begin
                            fin.dv = m_tx[m_txpos];
                        end
                    end else begin
                        fin.en = 1; fin.dv = sbcs_pkg::SYM_JAM; fin.st = sbcs_pkg::ST_JAM;
                        if (m_coll < 15) m_coll++;
                        m_jam_own = 1;
                        m_txpos = 0;
                        if (m_coll >= m_limit) begin
                            drop_msg();
                            fin.st = sbcs_pkg::ST_GAVE_UP;
                        end
                    end
                end else if (m_rxcnt < DEPTH) begin
                    m_rx[m_rxcnt] = c; m_rxcnt++;
                end
            end
            if (m_boff > 0) m_boff--;
        end
        last_en = fin.en;
        last_dv = fin.dv;
    endtask

    // drives one transaction and waits for it to be taken
    task automatic send_item(input logic act, input logic [7:0] c,
                             input logic [15:0] rnd, input logic [7:0] tb,
                             input logic tl);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 82 : (idle_mode == 3) ? 16 : 0;
        while ($urandom_range(0, 99) < gap_pct) @(negedge i_clk);
        i_valid = 1'b1;
        i_action = act; i_channel_value = c; i_random_value = rnd;
        i_tx_byte = tb; i_tx_last = tl;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [3:0] val);
        i_cfg_we = 1'b1; i_cfg_index = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            sbcs_pkg::CFG_ATTEMPT_LIMIT: m_limit = val;
            sbcs_pkg::CFG_BACKOFF_STEP:  m_step = val;
            default:                     m_hold = val[1:0];
        endcase
    endtask

    task automatic drain_wait(input int extra);
        while (station_outs.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // directed table
    t_dir_row dir_rows[] = '{
        // first idle after reset only counts the hold
        '{1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 1, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        // bad load bytes, then a two-byte message
        '{1'b1, 8'h00, 16'h0000, 8'h00, 1'b0, 1, 1'b0, 8'h00, sbcs_pkg::ST_REJECTED},
        '{1'b1, 8'h00, 16'h0000, 8'hFE, 1'b1, 1, 1'b0, 8'h00, sbcs_pkg::ST_REJECTED},
        '{1'b1, 8'h00, 16'h0000, 8'hFF, 1'b1, 1, 1'b0, 8'h00, sbcs_pkg::ST_REJECTED},
        '{1'b1, 8'h00, 16'h0000, 8'h01, 1'b0, 1, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b1, 8'h00, 16'h0000, 8'hFD, 1'b1, 1, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        // load while pending
        '{1'b1, 8'h00, 16'h0000, 8'h10, 1'b1, 1, 1'b0, 8'h00, sbcs_pkg::ST_REJECTED},
        // a foreign byte collides with the pending message, then idle to claim
        '{1'b0, 8'h80, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'hFF, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'h01, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        // collision on the second byte, jam, backoff from a full random value
        '{1'b0, 8'h55, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'hFE, 16'hFFFF, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'hFF, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'hFD, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE},
        '{1'b0, 8'h00, 16'h0000, 8'h00, 1'b0, 0, 1'b0, 8'h00, sbcs_pkg::ST_NONE}
    };

    // one random transaction, shaped by what the station is doing
    int load_left = 0;
    int burst_left = 0;
    task automatic random_item();
        logic [7:0]   c;
        logic [15:0]  rnd;
        logic [7:0]   tb;
        t_station_out fin;
        int           r;
        r = $urandom_range(0, 99);
        rnd = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 15))
                                           : 16'($urandom_range(0, 65535));
        tb = 8'($urandom_range(1, 253));
        if (load_left > 0) begin
            load_left--;
            if (r < 3) tb = (r == 0) ? sbcs_pkg::SYM_IDLE
                          : (r == 1) ? sbcs_pkg::SYM_JAM : sbcs_pkg::SYM_CLAIM;
            station_predict(1'b1, '0, rnd, tb, load_left == 0, fin);
            station_outs.push_back(fin);
            send_item(1'b1, 8'($urandom), 16'($urandom), tb, load_left == 0);
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
            c = 8'($urandom_range(1, 253));
        end else if (!m_ready && r < 25) begin
            // new message; now and then one too long for the store
            load_left = ($urandom_range(0, 19) == 0) ? 34 : $urandom_range(1, 4);
            c = 8'h00;
            load_left--;
            station_predict(1'b1, '0, rnd, tb, load_left == 0, fin);
            station_outs.push_back(fin);
            send_item(1'b1, '0, rnd, tb, load_left == 0);
            return;
        end else if (r < 27) begin
            burst_left = 36;
            c = 8'($urandom_range(1, 253));
        end else if (last_en && last_dv != sbcs_pkg::SYM_IDLE && r < 87) begin
            c = last_dv;
        end else begin
            r = $urandom_range(0, 99);
            c = (r < 55) ? sbcs_pkg::SYM_IDLE : (r < 65) ? sbcs_pkg::SYM_CLAIM
              : (r < 72) ? sbcs_pkg::SYM_JAM : 8'($urandom);
        end
        station_predict(1'b0, c, rnd, tb, 1'b0, fin);
        station_outs.push_back(fin);
        send_item(1'b0, c, rnd, tb, 1'($urandom));
    endtask

    // stimulus
    initial begin
        t_station_out fin;
        logic [3:0]   phase_cfg[6][3] = '{
            '{4'd10, 4'd8, 4'd2}, '{4'd15, 4'd15, 4'd3}, '{4'd1, 4'd0, 4'd0},
            '{4'd0, 4'd1, 4'd1}, '{4'd3, 4'd15, 4'd0}, '{4'd15, 4'd1, 4'd3}
        };
        station_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            station_predict(dir_rows[k].act, dir_rows[k].ch, dir_rows[k].rnd,
                            dir_rows[k].tb, dir_rows[k].tl, fin);
            if (dir_rows[k].typed) begin
                fin = '{kind: 1'b0, en: dir_rows[k].t_en, dv: dir_rows[k].t_dv,
                        rb: 8'h00, last: 1'b1, st: dir_rows[k].t_st};
            end
            station_outs.push_back(fin);
            send_item(dir_rows[k].act, dir_rows[k].ch, dir_rows[k].rnd,
                      dir_rows[k].tb, dir_rows[k].tl);
        end

        for (int p = 0; p < 12; p++) begin
            drain_wait(40);
            cfg_write(sbcs_pkg::CFG_ATTEMPT_LIMIT, phase_cfg[p % 6][0]);
            cfg_write(sbcs_pkg::CFG_BACKOFF_STEP, phase_cfg[p % 6][1]);
            cfg_write(sbcs_pkg::CFG_IDLE_HOLD, phase_cfg[p % 6][2]);
            idle_mode = p % 4;
            for (int n = 0; n < N_RANDOM / 12 || load_left > 0; n++) random_item();
        end

        idle_mode = 0;
        drain_wait(60);
        if (fail_cnt == 0) begin
            $display("shared_bus_collision_station_core verification clean");
        end else begin
            $display("shared_bus_collision_station_core verification failed");
        end
        $finish;
    end
endmodule
